// ===== sv/mme_pkg.sv =====
package mme_pkg;

    localparam int MAX_DIM     = 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int OPND_W      = 16;
    localparam int PROD_W      = 2 * OPND_W;
    localparam int SUM_W       = 32;
    localparam int ACC_W       = PROD_W + $clog2(MAX_DIM) + 1;

    typedef enum logic [1:0] {
        KIND_LOAD_LEFT  = 2'd0,
        KIND_LOAD_RIGHT = 2'd1,
        KIND_RUN        = 2'd2
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_K = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_N  = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    // Tag that travels down the datapath alongside each pair of operands.
    typedef struct packed {
        logic             first;
        logic             lastk;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             last;
    } tag_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        d = v;
        if (d == '0) begin
            d = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end
        return d;
    endfunction

    function automatic logic [SUM_W-1:0] saturate(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic [SUM_W-1:0]        r;
        hi = {{(ACC_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
        lo = {{(ACC_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};
        if (a > hi) begin
            r = hi[SUM_W-1:0];
        end else if (a < lo) begin
            r = lo[SUM_W-1:0];
        end else begin
            r = a[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/matrix_multiply_engine.sv =====
// Matrix multiply engine: loads a left (m by k) and a right (k by n) matrix of
// signed Q8.8 elements into two 64-entry stores, then streams out the m by n
// product in row-major order as saturated signed Q16.16 sums.
// Input channel (s_*): kind 0 loads a left element, kind 1 a right element at
// the given row-major index; kind 2 starts a multiply. Loads beyond the current
// dimensions and kind 3 are dropped and give no item out.
// Result channel (m_*): one item per product element, with row, column, sum
// and a last flag on the final element.
// Loads stream at one item per cycle while no run holds s_ready low. A run
// walks m*n*k multiply-accumulates, one per cycle unless frozen, through the
// store read port, the multiplier and the accumulator. m_valid first rises
// once the first dot product is summed, and each further item follows as its
// dot product is finished. s_ready stays low while reads issue, even if frozen.
// When the receiver stalls, the finished sum waits in the output register and
// the read/multiply pipeline carries on until the next sum is finished; it
// then freezes until the waiting item is taken.
// Configuration (cfg_*) sets rows_m, inner_k and cols_n; 0 reads as 1 and values
// above 8 read as 8. Reset sets all three to 8 and empties the pipeline; store
// contents are undefined until written.
module matrix_multiply_engine (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mme_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]          cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_kind,
    input  logic [5:0]                         s_element_index,
    input  logic signed [15:0]                 s_operand_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [2:0]                         m_result_row,
    output logic [2:0]                         m_result_col,
    output logic signed [31:0]                 m_sum_value,
    output logic                               m_last
);
    import mme_pkg::*;

    logic [DIM_W-1:0]    rows_m_reg;
    logic [DIM_W-1:0]    inner_k_reg;
    logic [DIM_W-1:0]    cols_n_reg;

    logic                s_accept;
    logic                start;
    logic                left_we;
    logic                right_we;
    logic [IDX_W:0]      left_count;
    logic [IDX_W:0]      right_count;
    logic                adv;
    logic                issue;
    tag_t                issue_tag;
    logic [IDX_W-1:0]    left_addr;
    logic [IDX_W-1:0]    right_addr;
    logic [OPND_W-1:0]   left_rdata;
    logic [OPND_W-1:0]   right_rdata;
    logic [SUM_W-1:0]    sum_bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_m_reg  <= DIM_RESET;
            inner_k_reg <= DIM_RESET;
            cols_n_reg  <= DIM_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_ROWS_M) begin
                rows_m_reg <= clamp_dim(cfg_wdata);
            end
            if (cfg_index == CFG_INNER_K) begin
                inner_k_reg <= clamp_dim(cfg_wdata);
            end
            if (cfg_index == CFG_COLS_N) begin
                cols_n_reg <= clamp_dim(cfg_wdata);
            end
        end
    end

    assign left_count  = (IDX_W+1)'(rows_m_reg) * (IDX_W+1)'(inner_k_reg);
    assign right_count = (IDX_W+1)'(inner_k_reg) * (IDX_W+1)'(cols_n_reg);

    assign s_accept = s_valid && s_ready;
    assign start    = s_accept && (s_kind == KIND_RUN);
    assign left_we  = s_accept && (s_kind == KIND_LOAD_LEFT)
                      && ({1'b0, s_element_index} < left_count);
    assign right_we = s_accept && (s_kind == KIND_LOAD_RIGHT)
                      && ({1'b0, s_element_index} < right_count);

    mme_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .adv        (adv),
        .dim_m      (rows_m_reg),
        .dim_k      (inner_k_reg),
        .dim_n      (cols_n_reg),
        .ready      (s_ready),
        .issue      (issue),
        .issue_tag  (issue_tag),
        .left_addr  (left_addr),
        .right_addr (right_addr)
    );

    mme_ram #(
        .WIDTH (OPND_W),
        .DEPTH (STORE_DEPTH)
    ) u_left_store (
        .aclk    (aclk),
        .wr_en   (left_we),
        .wr_addr (s_element_index),
        .wr_data (s_operand_value),
        .rd_en   (issue),
        .rd_addr (left_addr),
        .rd_data (left_rdata)
    );

    mme_ram #(
        .WIDTH (OPND_W),
        .DEPTH (STORE_DEPTH)
    ) u_right_store (
        .aclk    (aclk),
        .wr_en   (right_we),
        .wr_addr (s_element_index),
        .wr_data (s_operand_value),
        .rd_en   (issue),
        .rd_addr (right_addr),
        .rd_data (right_rdata)
    );

    mme_mac u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue       (issue),
        .issue_tag   (issue_tag),
        .left_rdata  (signed'(left_rdata)),
        .right_rdata (signed'(right_rdata)),
        .adv         (adv),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row       (m_result_row),
        .m_col       (m_result_col),
        .m_sum       (sum_bits),
        .m_last      (m_last)
    );

    assign m_sum_value = signed'(sum_bits);

endmodule

// ===== sv/mme_ram.sv =====
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/mme_seq.sv =====
module mme_seq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         adv,
    input  logic [mme_pkg::DIM_W-1:0]    dim_m,
    input  logic [mme_pkg::DIM_W-1:0]    dim_k,
    input  logic [mme_pkg::DIM_W-1:0]    dim_n,
    output logic                         ready,
    output logic                         issue,
    output mme_pkg::tag_t                issue_tag,
    output logic [mme_pkg::IDX_W-1:0]    left_addr,
    output logic [mme_pkg::IDX_W-1:0]    right_addr
);
    import mme_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] inr_reg;
    logic [IDX_W-1:0] la_reg;
    logic [IDX_W-1:0] ra_reg;
    logic [IDX_W-1:0] rb_reg;

    logic [CNT_W-1:0] m_top;
    logic [CNT_W-1:0] k_top;
    logic [CNT_W-1:0] n_top;
    logic             end_dot;
    logic             end_row;
    logic             end_all;
    logic [IDX_W-1:0] rb_next;

    assign m_top   = CNT_W'(dim_m - DIM_W'(1));
    assign k_top   = CNT_W'(dim_k - DIM_W'(1));
    assign n_top   = CNT_W'(dim_n - DIM_W'(1));
    assign end_dot = (inr_reg == k_top);
    assign end_row = end_dot && (col_reg == n_top);
    assign end_all = end_row && (row_reg == m_top);
    assign rb_next = IDX_W'(rb_reg + IDX_W'(dim_k));

    assign ready      = (state_reg == ST_IDLE);
    assign issue      = (state_reg == ST_RUN) && adv;
    assign left_addr  = la_reg;
    assign right_addr = ra_reg;

    always_comb begin
        issue_tag.first = (inr_reg == '0);
        issue_tag.lastk = end_dot;
        issue_tag.row   = row_reg;
        issue_tag.col   = col_reg;
        issue_tag.last  = (row_reg == m_top) && (col_reg == n_top);
    end

    // Addresses step incrementally: left walks along a row, right down a column.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            inr_reg   <= '0;
            la_reg    <= '0;
            ra_reg    <= '0;
            rb_reg    <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        state_reg <= ST_RUN;
                        row_reg   <= '0;
                        col_reg   <= '0;
                        inr_reg   <= '0;
                        la_reg    <= '0;
                        ra_reg    <= '0;
                        rb_reg    <= '0;
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        if (end_all) begin
                            state_reg <= ST_IDLE;
                        end else if (end_row) begin
                            inr_reg <= '0;
                            col_reg <= '0;
                            row_reg <= row_reg + CNT_W'(1);
                            rb_reg  <= rb_next;
                            la_reg  <= rb_next;
                            ra_reg  <= '0;
                        end else if (end_dot) begin
                            inr_reg <= '0;
                            col_reg <= col_reg + CNT_W'(1);
                            la_reg  <= rb_reg;
                            ra_reg  <= IDX_W'(col_reg) + IDX_W'(1);
                        end else begin
                            inr_reg <= inr_reg + CNT_W'(1);
                            la_reg  <= la_reg + IDX_W'(1);
                            ra_reg  <= IDX_W'(ra_reg + IDX_W'(dim_n));
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/mme_mac.sv =====
module mme_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                issue,
    input  mme_pkg::tag_t                       issue_tag,
    input  logic signed [mme_pkg::OPND_W-1:0]   left_rdata,
    input  logic signed [mme_pkg::OPND_W-1:0]   right_rdata,
    output logic                                adv,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mme_pkg::CNT_W-1:0]           m_row,
    output logic [mme_pkg::CNT_W-1:0]           m_col,
    output logic [mme_pkg::SUM_W-1:0]           m_sum,
    output logic                                m_last
);
    import mme_pkg::*;

    logic                     s1_valid_reg;
    tag_t                     s1_tag_reg;
    logic                     s2_valid_reg;
    tag_t                     s2_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     out_valid_reg;
    logic [CNT_W-1:0]         out_row_reg;
    logic [CNT_W-1:0]         out_col_reg;
    logic [SUM_W-1:0]         out_sum_reg;
    logic                     out_last_reg;
    logic                     finish;

    // The whole pipeline freezes while a finished sum waits for a full output register.
    assign finish   = s2_valid_reg && s2_tag_reg.lastk;
    assign adv      = !(finish && out_valid_reg && !m_ready);
    assign acc_next = (s2_tag_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv && finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tag_reg <= issue_tag;
            s2_tag_reg <= s1_tag_reg;
            prod_reg   <= left_rdata * right_rdata;
            if (s2_valid_reg) begin
                acc_reg <= acc_next;
            end
            if (finish) begin
                out_row_reg  <= s2_tag_reg.row;
                out_col_reg  <= s2_tag_reg.col;
                out_sum_reg  <= saturate(acc_next);
                out_last_reg <= s2_tag_reg.last;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_row   = out_row_reg;
    assign m_col   = out_col_reg;
    assign m_sum   = out_sum_reg;
    assign m_last  = out_last_reg;

    a_issue_only_when_moving: assert property (
        @(posedge aclk) disable iff (!aresetn) issue |-> adv
    ) else $error("read issued while the pipeline is frozen");

    a_finish_fills_output: assert property (
        @(posedge aclk) disable iff (!aresetn) (adv && finish) |=> out_valid_reg
    ) else $error("completed sum did not reach the output register");

    a_freeze_holds_pipeline: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(s2_valid_reg) && $stable(prod_reg) && $stable(s1_valid_reg))
    ) else $error("pipeline moved while frozen");

endmodule
